// ===== sv/ppi_pkg.sv =====
// ============================================================================
// ppi_pkg
// Shared types and constants for the planar pose integrator.
// ============================================================================
package ppi_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd2;

    localparam logic signed [39:0] POS_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] POS_MIN = 40'sh80_0000_0000;

    localparam logic signed [15:0] HEADING_INIT = -16'sd8192;

    // CORDIC datapath, Q4.30 (34-bit signed)
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;

    // constant divider: dividend < 2^58, quotient < 2^37, 13-bit quotient digits
    localparam int DIV_NW     = 58;
    localparam int DIV_QW     = 37;
    localparam int DIV_DW     = 23;
    localparam int DIV_KW     = 13;
    localparam int DIV_DIGITS = 3;
    localparam int DIV_SW     = DIV_KW * DIV_DIGITS;
    localparam int DIV_VW     = DIV_DW + DIV_KW;
    localparam int DIV_RW     = 15;

    localparam logic [DIV_DW-1:0] VEL_DIV  = 23'd3906250;
    localparam logic [DIV_DW-1:0] VEL_HALF = 23'd1953125;
    localparam logic [DIV_DW-1:0] ANG_DIV  = 23'd6283185;
    localparam logic [DIV_DW-1:0] ANG_HALF = 23'd3141592;

    // ceil(2^36 / divisor)
    localparam logic [DIV_RW-1:0] VEL_RECIP = 15'd17593;
    localparam logic [DIV_RW-1:0] ANG_RECIP = 15'd10938;

    typedef struct packed {
        logic              first;
        logic [31:0]       dt;
        logic signed [23:0] forward_rate;
        logic signed [23:0] lateral_rate;
        logic signed [23:0] turn_rate;
    } ppi_item_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] r;
        case (idx)
            5'd0:    r = 34'sd843314856;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043836;
            5'd3:    r = 34'sd133525158;
            5'd4:    r = 34'sd67021686;
            5'd5:    r = 34'sd33543515;
            5'd6:    r = 34'sd16775850;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194282;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048575;
            5'd11:   r = 34'sd524287;
            5'd12:   r = 34'sd262143;
            5'd13:   r = 34'sd131071;
            5'd14:   r = 34'sd65535;
            5'd15:   r = 34'sd32767;
            5'd16:   r = 34'sd16383;
            5'd17:   r = 34'sd8191;
            5'd18:   r = 34'sd4095;
            5'd19:   r = 34'sd2047;
            5'd20:   r = 34'sd1023;
            5'd21:   r = 34'sd511;
            5'd22:   r = 34'sd255;
            5'd23:   r = 34'sd127;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/ppi_div.sv =====
// ============================================================================
// ppi_div
// Constant divider: 13-bit quotient digits by reciprocal estimate and one
// correction; each digit runs a reciprocal, a divisor and a fix-up step.
// ============================================================================
module ppi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ppi_pkg::DIV_NW-1:0]    dividend,
    input  logic [ppi_pkg::DIV_DW-1:0]    divisor,
    input  logic [ppi_pkg::DIV_RW-1:0]    recip,
    output logic                          done,
    output logic [ppi_pkg::DIV_QW-1:0]    quotient
);
    import ppi_pkg::*;

    typedef enum logic [2:0] {
        ST_RCP = 3'b001,
        ST_DSR = 3'b010,
        ST_FIX = 3'b100
    } step_t;

    logic                     busy_reg;
    logic                     done_reg;
    step_t                    step_reg;
    logic [1:0]               dig_reg;
    logic [DIV_DW-1:0]        rem_reg;
    logic [DIV_DW-1:0]        dsr_reg;
    logic [DIV_RW-1:0]        rcp_reg;
    logic [DIV_SW-1:0]        sh_reg;
    logic [DIV_VW+DIV_RW-1:0] prod_reg;
    logic [DIV_KW:0]          qe_reg;
    logic [DIV_KW+DIV_DW:0]   qd_reg;
    logic [DIV_VW-1:0]        part;
    logic [DIV_KW:0]          qe;
    logic [DIV_VW+1:0]        diff;
    logic                     neg;
    logic [DIV_DW-1:0]        rem_fix;
    logic [DIV_KW-1:0]        q_fix;

    // partial remainder < divisor * 2^13, so the estimate is exact or one high
    assign part    = {rem_reg, sh_reg[DIV_SW-1 -: DIV_KW]};
    assign qe      = prod_reg[DIV_VW+DIV_KW:DIV_VW];
    assign diff    = {2'b00, part} - {1'b0, qd_reg};
    assign neg     = diff[DIV_VW+1];
    assign rem_fix = neg ? (diff[DIV_DW-1:0] + dsr_reg) : diff[DIV_DW-1:0];
    assign q_fix   = neg ? (qe_reg[DIV_KW-1:0] - 1'b1) : qe_reg[DIV_KW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= ST_RCP;
            dig_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= ST_RCP;
                dig_reg  <= '0;
            end
            else if (busy_reg)
            begin
                unique case (step_reg)
                    ST_RCP:  step_reg <= ST_DSR;
                    ST_DSR:  step_reg <= ST_FIX;
                    ST_FIX:
                    begin
                        step_reg <= ST_RCP;
                        dig_reg  <= dig_reg + 1'b1;
                        if (dig_reg == 2'(DIV_DIGITS - 1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    default: step_reg <= ST_RCP;
                endcase
            end
        end
    end

    // top bits of the dividend are already below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DIV_DW'(dividend[DIV_NW-1:DIV_SW]);
            sh_reg  <= dividend[DIV_SW-1:0];
            dsr_reg <= divisor;
            rcp_reg <= recip;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                ST_RCP:
                    prod_reg <= (DIV_VW+DIV_RW)'(part) * (DIV_VW+DIV_RW)'(rcp_reg);
                ST_DSR:
                begin
                    qe_reg <= qe;
                    qd_reg <= (DIV_KW+DIV_DW+1)'(qe) * (DIV_KW+DIV_DW+1)'(dsr_reg);
                end
                ST_FIX:
                begin
                    rem_reg <= rem_fix;
                    sh_reg  <= {sh_reg[DIV_SW-DIV_KW-1:0], q_fix};
                end
                default: rem_reg <= rem_reg;
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg[DIV_QW-1:0];

endmodule

// ===== sv/ppi_front.sv =====
// ============================================================================
// ppi_front
// Accepts items, derives elapsed time and first-item flag, two-entry queue.
// ============================================================================
module ppi_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [31:0]        timestamp_us,
    input  logic signed [23:0] forward_rate,
    input  logic signed [23:0] lateral_rate,
    input  logic signed [23:0] turn_rate,
    input  logic [31:0]        start_time,
    output logic               q_valid,
    input  logic               q_pop,
    output ppi_pkg::ppi_item_t q_item
);
    import ppi_pkg::*;

    logic        started_reg;
    logic [31:0] prev_reg;
    logic [1:0]  count_reg;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    ppi_item_t   mem [2];
    ppi_item_t   new_item;
    logic        accept;
    logic        take;

    assign accept = push && !full;
    assign take   = q_pop && q_valid;
    assign full   = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;

    always_comb
    begin
        new_item.first        = !started_reg;
        new_item.dt           = timestamp_us - (started_reg ? prev_reg : start_time);
        new_item.forward_rate = forward_rate;
        new_item.lateral_rate = lateral_rate;
        new_item.turn_rate    = turn_rate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            count_reg   <= '0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                started_reg <= 1'b1;
                wr_ptr_reg  <= !wr_ptr_reg;
            end
            if (take)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, accept} - {1'b0, take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_reg        <= timestamp_us;
            mem[wr_ptr_reg] <= new_item;
        end
    end

    assign q_item = mem[rd_ptr_reg];

endmodule

// ===== sv/ppi_back.sv =====
// ============================================================================
// ppi_back
// Sequencer: CORDIC rotation, shared multiplier, constant divides, result reg.
// ============================================================================
module ppi_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  ppi_pkg::ppi_item_t q_item,
    input  logic signed [39:0] initial_x,
    input  logic signed [39:0] initial_y,
    output logic               empty,
    input  logic               pop,
    output logic signed [39:0] pose_x,
    output logic signed [39:0] pose_y,
    output logic signed [15:0] heading_angle,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w
);
    import ppi_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_ANG    = 14'b00000000000010,
        S_CINIT  = 14'b00000000000100,
        S_CORD   = 14'b00000000001000,
        S_CFIN   = 14'b00000000010000,
        S_PFC    = 14'b00000000100000,
        S_PLS    = 14'b00000001000000,
        S_QFS    = 14'b00000010000000,
        S_QLC    = 14'b00000100000000,
        S_QSUM   = 14'b00001000000000,
        S_MUL    = 14'b00010000000000,
        S_DSTART = 14'b00100000000000,
        S_DWAIT  = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    typedef enum logic [2:0] {
        PH_X = 3'b001,
        PH_Y = 3'b010,
        PH_H = 3'b100
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg;
    logic   pass_reg;   // 0: velocity rotation, 1: quaternion
    logic   flip_reg;

    logic [31:0]        dt_reg;
    logic signed [23:0] fwd_reg, lat_reg, turn_reg;
    logic signed [39:0] pos_x_reg, pos_y_reg;
    logic signed [15:0] heading_reg;
    logic signed [59:0] mul_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [IW-1:0]      i_reg;
    logic signed [16:0] c_reg, s_reg;
    logic signed [40:0] acc_reg;
    logic signed [25:0] p_reg, q_reg;
    logic               sign_reg;
    logic               out_valid_reg;
    logic signed [39:0] out_x_reg, out_y_reg;
    logic signed [15:0] out_h_reg, out_z_reg, out_w_reg;

    logic signed [25:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [15:0] b_adj;
    logic               flip_now;
    logic signed [33:0] xs, ys, at;
    logic [40:0]        p_sum, q_sum;
    logic [59:0]        mag;
    logic               div_start, div_done;
    logic [DIV_NW-1:0]  div_dividend;
    logic [DIV_DW-1:0]  div_divisor, div_half;
    logic [DIV_RW-1:0]  div_recip;
    logic [DIV_QW-1:0]  div_quot;
    logic signed [40:0] qs;
    logic               done_fire;
    logic               last_step;

    function automatic logic signed [16:0] to_q15(input logic signed [33:0] v);
        logic signed [33:0] r;
        logic signed [16:0] o;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)
            o = 17'sd32767;
        else if (r < -34'sd32768)
            o = -17'sd32768;
        else
            o = r[16:0];
        return o;
    endfunction

    function automatic logic signed [39:0] sat_add(input logic signed [39:0] pos,
                                                   input logic signed [40:0] d);
        logic signed [40:0] s;
        logic signed [39:0] o;
        s = {pos[39], pos} + d;
        if (s > 41'(POS_MAX))
            o = POS_MAX;
        else if (s < 41'(POS_MIN))
            o = POS_MIN;
        else
            o = s[39:0];
        return o;
    endfunction

    // fold heading into [-pi/2, pi/2) by toggling the half-turn bit
    assign flip_now = heading_reg[15] ^ heading_reg[14];
    assign b_adj    = flip_now ? {~heading_reg[15], heading_reg[14:0]} : heading_reg;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = atan_q30(5'(i_reg));
    assign last_step = i_reg == IW'(CORDIC_STEPS - 1);

    assign p_sum = acc_reg - mul_reg[40:0] + 41'sd16384;
    assign q_sum = acc_reg + mul_reg[40:0] + 41'sd16384;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ANG:
            begin
                mul_a = pass_reg ? 26'(heading_reg) : 26'(b_adj);
                mul_b = PI_Q30;
            end
            S_PFC:
            begin
                mul_a = 26'(fwd_reg);
                mul_b = 34'(c_reg);
            end
            S_PLS:
            begin
                mul_a = 26'(lat_reg);
                mul_b = 34'(s_reg);
            end
            S_QFS:
            begin
                mul_a = 26'(fwd_reg);
                mul_b = 34'(s_reg);
            end
            S_QLC:
            begin
                mul_a = 26'(lat_reg);
                mul_b = 34'(c_reg);
            end
            S_MUL:
            begin
                mul_b = 34'(dt_reg);
                unique case (phase_reg)
                    PH_X:    mul_a = p_reg;
                    PH_Y:    mul_a = q_reg;
                    PH_H:    mul_a = 26'(turn_reg);
                    default: mul_a = '0;
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half away from zero: |n| + d/2, then divide
    assign mag          = mul_reg[59] ? 60'(-mul_reg) : 60'(mul_reg);
    assign div_half     = (phase_reg == PH_H) ? ANG_HALF : VEL_HALF;
    assign div_divisor  = (phase_reg == PH_H) ? ANG_DIV : VEL_DIV;
    assign div_recip    = (phase_reg == PH_H) ? ANG_RECIP : VEL_RECIP;
    assign div_dividend = mag[DIV_NW-1:0] + DIV_NW'(div_half);
    assign div_start    = state_reg == S_DSTART;
    assign qs = sign_reg ? -$signed(41'(div_quot)) : $signed(41'(div_quot));

    ppi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .recip    (div_recip),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || pop);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (q_valid) state_next = S_ANG;
            S_ANG:    state_next = S_CINIT;
            S_CINIT:  state_next = S_CORD;
            S_CORD:   if (last_step) state_next = S_CFIN;
            S_CFIN:   state_next = pass_reg ? S_DONE : S_PFC;
            S_PFC:    state_next = S_PLS;
            S_PLS:    state_next = S_QFS;
            S_QFS:    state_next = S_QLC;
            S_QLC:    state_next = S_QSUM;
            S_QSUM:   state_next = S_MUL;
            S_MUL:    state_next = S_DSTART;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
                if (div_done)
                    state_next = (phase_reg == PH_H) ? S_ANG : S_MUL;
            S_DONE:   if (done_fire) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_X;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                pass_reg  <= 1'b0;
                phase_reg <= PH_X;
            end
            else if (state_reg == S_DWAIT && div_done)
            begin
                unique case (phase_reg)
                    PH_X:    phase_reg <= PH_Y;
                    PH_Y:    phase_reg <= PH_H;
                    PH_H:    pass_reg  <= 1'b1;
                    default: phase_reg <= PH_X;
                endcase
            end
            if (done_fire)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    dt_reg   <= q_item.dt;
                    fwd_reg  <= q_item.forward_rate;
                    lat_reg  <= q_item.lateral_rate;
                    turn_reg <= q_item.turn_rate;
                    if (q_item.first)
                    begin
                        pos_x_reg   <= initial_x;
                        pos_y_reg   <= initial_y;
                        heading_reg <= HEADING_INIT;
                    end
                end
            end
            S_ANG:
            begin
                flip_reg <= pass_reg ? 1'b0 : flip_now;
            end
            S_CINIT:
            begin
                z_reg <= pass_reg ? mul_reg[49:16] : mul_reg[48:15];
                x_reg <= CORDIC_GAIN;
                y_reg <= '0;
                i_reg <= '0;
            end
            S_CORD:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 1'b1;
            end
            S_CFIN:
            begin
                c_reg <= flip_reg ? -to_q15(x_reg) : to_q15(x_reg);
                s_reg <= flip_reg ? -to_q15(y_reg) : to_q15(y_reg);
            end
            S_PLS:
            begin
                acc_reg <= mul_reg[40:0];
            end
            S_QFS:
            begin
                p_reg <= p_sum[40:15];
            end
            S_QLC:
            begin
                acc_reg <= mul_reg[40:0];
            end
            S_QSUM:
            begin
                q_reg <= q_sum[40:15];
            end
            S_DSTART:
            begin
                sign_reg <= mul_reg[59];
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    unique case (phase_reg)
                        PH_X:    pos_x_reg   <= sat_add(pos_x_reg, qs);
                        PH_Y:    pos_y_reg   <= sat_add(pos_y_reg, qs);
                        PH_H:    heading_reg <= heading_reg + qs[15:0];
                        default: heading_reg <= heading_reg;
                    endcase
                end
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    out_x_reg <= pos_x_reg;
                    out_y_reg <= pos_y_reg;
                    out_h_reg <= heading_reg;
                    out_w_reg <= c_reg[15:0];
                    out_z_reg <= s_reg[15:0];
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign empty         = !out_valid_reg;
    assign pose_x        = out_x_reg;
    assign pose_y        = out_y_reg;
    assign heading_angle = out_h_reg;
    assign quat_z        = out_z_reg;
    assign quat_w        = out_w_reg;

endmodule

// ===== sv/planar_pose_integrator_core.sv =====
// Each item is processed to completion before the next is taken from the input
// queue: two passes of the iterative CORDIC and three constant divides. Two
// items queue at the input and one finished result waits in the output reg.
// Reset: asynchronous, active low; clears control state and config registers,
// the first item after reset loads the start pose and start time.
// ============================================================================
// planar_pose_integrator_core
// Dead-reckoning pose integrator: queued front, sequenced back end.
// ============================================================================
module planar_pose_integrator_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppi_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [31:0]                         timestamp_us,
    input  logic signed [23:0]                  forward_rate,
    input  logic signed [23:0]                  lateral_rate,
    input  logic signed [23:0]                  turn_rate,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [39:0]                  pose_x,
    output logic signed [39:0]                  pose_y,
    output logic signed [15:0]                  heading_angle,
    output logic signed [15:0]                  quat_z,
    output logic signed [15:0]                  quat_w
);
    import ppi_pkg::*;

    logic signed [39:0] initial_x_reg, initial_y_reg;
    logic [31:0]        start_time_reg;
    logic               q_valid, q_pop;
    ppi_item_t          q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_x_reg  <= '0;
            initial_y_reg  <= '0;
            start_time_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INITIAL_X:  initial_x_reg  <= cfg_data;
                REG_INITIAL_Y:  initial_y_reg  <= cfg_data;
                REG_START_TIME: start_time_reg <= cfg_data[31:0];
                default:        start_time_reg <= start_time_reg;
            endcase
        end
    end

    ppi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .timestamp_us (timestamp_us),
        .forward_rate (forward_rate),
        .lateral_rate (lateral_rate),
        .turn_rate    (turn_rate),
        .start_time   (start_time_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item)
    );

    ppi_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .initial_x     (initial_x_reg),
        .initial_y     (initial_y_reg),
        .empty         (empty),
        .pop           (pop),
        .pose_x        (pose_x),
        .pose_y        (pose_y),
        .heading_angle (heading_angle),
        .quat_z        (quat_z),
        .quat_w        (quat_w)
    );

endmodule

// ===== sv/ppi_checker.sv =====
// ============================================================================
// ppi_checker
// Port-level checks on the pose integrator queues.
// ============================================================================
module ppi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [39:0] pose_x,
    input logic signed [39:0] pose_y,
    input logic signed [15:0] heading_angle
);
    logic [2:0] inflight_reg;
    logic       in_xfer, out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_reg + {2'b0, in_xfer} - {2'b0, out_xfer};
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> inflight_reg != 3'd0)
        else $error("result shown with no item in flight");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more items in flight than storage");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without transfer");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(pose_x) && $stable(pose_y)
                              && $stable(heading_angle)))
        else $error("result changed while waiting");

endmodule

bind planar_pose_integrator_core ppi_checker u_ppi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .pose_x        (pose_x),
    .pose_y        (pose_y),
    .heading_angle (heading_angle)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench for planar_pose_integrator_core. Items are queued and pushed by a
// clocked driver with random idle bursts. Results are popped by a clocked
// monitor with random stall bursts. Each result is checked field by field
// against an in-bench dead-reckoning predictor. Config writes happen only
// while the core is drained.
// ============================================================================
module tb_top;
    import ppi_pkg::*;

    localparam int   STEPS       = 16;
    localparam int   DRAIN_WAIT  = 250;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   PHASES      = 4;
    localparam int   PHASE_ITEMS = 100;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint PI_RAD_Q30  = 64'sd3373259426;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint US_PER_POS  = 64'sd3906250;
    localparam longint US_PER_TURN = 64'sd6283185;

    typedef struct {
        logic [31:0]        ts;
        logic signed [23:0] fwd;
        logic signed [23:0] lat;
        logic signed [23:0] turn;
    } motion_t;

    typedef struct {
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [15:0] heading;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } pose_t;

    logic clk, rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic push, full, empty, pop;
    logic [31:0] timestamp_us;
    logic signed [23:0] forward_rate, lateral_rate, turn_rate;
    logic signed [39:0] pose_x, pose_y;
    logic signed [15:0] heading_angle, quat_z, quat_w;

    planar_pose_integrator_core #(.CORDIC_STEPS(STEPS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .timestamp_us(timestamp_us), .forward_rate(forward_rate),
        .lateral_rate(lateral_rate), .turn_rate(turn_rate),
        .empty(empty), .pop(pop),
        .pose_x(pose_x), .pose_y(pose_y), .heading_angle(heading_angle),
        .quat_z(quat_z), .quat_w(quat_w)
    );

    motion_t motion_queue[$];
    pose_t   expected_poses[$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      calm = 0;

    // predictor state and config copy
    logic signed [39:0] init_x_reg, init_y_reg, est_x, est_y;
    logic [31:0]        start_time_reg, last_time;
    logic signed [15:0] est_heading;
    bit                 est_started;

    function automatic longint q15_round(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic void cordic_sin_cos(input longint angle, output longint c,
                                           output longint s);
        longint x, y, z, xs, ys;
        x = GAIN_Q30;
        y = 0;
        z = angle;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_q30(5'(i)));
            end
            else begin
                x += ys; y -= xs; z += longint'(atan_q30(5'(i)));
            end
        end
        c = q15_round(x);
        s = q15_round(y);
    endfunction

    function automatic longint div_nearest(input longint n, input longint d);
        longint m, q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic signed [39:0] clamp_pos(input longint v);
        if (v > longint'(POS_MAX)) return POS_MAX;
        if (v < longint'(POS_MIN)) return POS_MIN;
        return v[39:0];
    endfunction

    task automatic integrate_motion(input motion_t m);
        logic [31:0] dt32;
        longint dt, b, c, s, p, q, step, qz, qw;
        pose_t e;
        if (!est_started) begin
            est_x = init_x_reg;
            est_y = init_y_reg;
            last_time = start_time_reg;
            est_heading = HEADING_INIT;
            est_started = 1;
        end
        dt32 = m.ts - last_time;
        dt = longint'(dt32);
        last_time = m.ts;
        b = longint'(est_heading);
        if (b >= 16384) b -= 32768;
        else if (b < -16384) b += 32768;
        cordic_sin_cos((b * PI_RAD_Q30) >>> 15, c, s);
        if (b != longint'(est_heading)) begin
            c = -c; s = -s;
        end
        p = (longint'(m.fwd) * c - longint'(m.lat) * s + 16384) >>> 15;
        q = (longint'(m.fwd) * s + longint'(m.lat) * c + 16384) >>> 15;
        est_x = clamp_pos(longint'(est_x) + div_nearest(p * dt, US_PER_POS));
        est_y = clamp_pos(longint'(est_y) + div_nearest(q * dt, US_PER_POS));
        step = div_nearest(longint'(m.turn) * dt, US_PER_TURN);
        est_heading = est_heading + 16'(step);
        cordic_sin_cos((longint'(est_heading) * PI_RAD_Q30) >>> 16, qw, qz);
        e.x = est_x;
        e.y = est_y;
        e.heading = est_heading;
        e.qz = qz[15:0];
        e.qw = qw[15:0];
        expected_poses.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    motion_t held;
    int      push_idle = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push <= 0;
            timestamp_us <= '0;
            forward_rate <= '0;
            lateral_rate <= '0;
            turn_rate <= '0;
        end
        else begin
            if (push && !full) integrate_motion(held);
            if (!push || !full) begin
                if (push_idle > 0) begin
                    push_idle--;
                    push <= 0;
                end
                else if (motion_queue.size() > 0) begin
                    held = motion_queue.pop_front();
                    timestamp_us <= held.ts;
                    forward_rate <= held.fwd;
                    lateral_rate <= held.lat;
                    turn_rate <= held.turn;
                    push <= 1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        push_idle = $urandom_range(1, 8);
                end
                else push <= 0;
            end
        end
    end

    // monitor
    int pop_idle = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) pop <= 0;
        else begin
            if (pop && !empty) begin
                if (expected_poses.size() == 0) begin
                    error_count++;
                    $display("MISMATCH unexpected result transfer at %0t", $realtime);
                end
                else begin
                    pose_t e;
                    e = expected_poses.pop_front();
                    if (pose_x !== e.x) report_mismatch("pose_x", pose_x, e.x);
                    if (pose_y !== e.y) report_mismatch("pose_y", pose_y, e.y);
                    if (heading_angle !== e.heading)
                        report_mismatch("heading_angle", heading_angle, e.heading);
                    if (quat_z !== e.qz) report_mismatch("quat_z", quat_z, e.qz);
                    if (quat_w !== e.qw) report_mismatch("quat_w", quat_w, e.qw);
                end
            end
            if (pop_idle > 0) begin
                pop_idle--;
                pop <= 0;
            end
            else begin
                pop <= 1;
                if (!calm && $urandom_range(0, 4) == 0) pop_idle = $urandom_range(1, 8);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("planar_pose_integrator_core verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 0;
        // registers only matter before the first transfer
        if (!est_started) begin
            if (idx == REG_INITIAL_X) init_x_reg = value;
            else if (idx == REG_INITIAL_Y) init_y_reg = value;
            else if (idx == REG_START_TIME) start_time_reg = value[31:0];
        end
    endtask

    task automatic wait_drained();
        while (motion_queue.size() > 0 || push || expected_poses.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic signed [23:0] pick_rate(input int span);
        if ($urandom_range(0, 2) == 0) return 24'($urandom);
        return 24'($urandom_range(0, 2 * span) - span);
    endfunction

    logic [31:0] now_us;

    task automatic add_motion(input logic [31:0] ts, input logic signed [23:0] f,
                              input logic signed [23:0] l, input logic signed [23:0] t);
        motion_t m;
        m.ts = ts; m.fwd = f; m.lat = l; m.turn = t;
        motion_queue.push_back(m);
        now_us = ts;
    endtask

    initial begin
        rst_n = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        init_x_reg = '0;
        init_y_reg = '0;
        start_time_reg = '0;
        est_x = '0;
        est_y = '0;
        last_time = '0;
        est_heading = HEADING_INIT;
        est_started = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        write_reg(REG_INITIAL_X, POS_MAX);
        write_reg(REG_INITIAL_Y, POS_MIN);
        write_reg(REG_START_TIME, 40'h00_FFFF_FFF0);
        write_reg(REG_UNUSED, '1);

        // directed: field extremes, zero interval, clock wrap, heading sweep
        add_motion(32'd10000, 24'sh7FFFFF, 24'sd0, 24'sd0);
        add_motion(32'd20000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
        add_motion(32'd30000, 24'sd0, 24'sh800000, 24'sh800000);
        add_motion(32'd30000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        add_motion(32'd0, 24'sd256, -24'sd256, 24'sd1000);
        add_motion(32'hFFFF_FFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        add_motion(32'd0, 24'sh800000, 24'sh800000, 24'sh800000);
        for (int i = 0; i < 14; i++)
            add_motion(now_us + 32'd40000, 24'sd2560, -24'sd1280,
                       24'sd1200000 + 24'(i * 91000));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_INITIAL_X, POS_MIN);
                    write_reg(REG_START_TIME, 40'd0);
                end
                1: begin
                    write_reg(REG_INITIAL_Y, POS_MAX);
                    write_reg(REG_START_TIME, 40'h00_FFFF_FFFF);
                end
                default: begin
                    write_reg(REG_INITIAL_X, 40'($urandom) << 8);
                    write_reg(REG_INITIAL_Y, 40'($urandom));
                    write_reg(REG_START_TIME, 40'($urandom));
                end
            endcase
            calm = (ph == PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                logic [31:0] ts;
                if ($urandom_range(0, 19) == 0) ts = $urandom;
                else ts = now_us + $urandom_range(500, 30000);
                add_motion(ts, pick_rate(65536), pick_rate(65536), pick_rate(131072));
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("planar_pose_integrator_core verification clean");
        else
            $display("planar_pose_integrator_core verification failed");
        $finish;
    end
endmodule
